// ----- hw/rtl/rsrf_pkg.sv -----
package rsrf_pkg;

    // default size of the key store
    localparam int unsigned STORE_DEPTH_DEFAULT = 1024;

    // key width
    localparam int unsigned KEY_W = 32;

    // action codes of an input item
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_RECORD = 2'd1;
    localparam logic [1:0] ACT_NEXT   = 2'd2;

    // status codes of a result item
    localparam logic [1:0] ST_ENTERED  = 2'd0;
    localparam logic [1:0] ST_DEFERRED = 2'd1;
    localparam logic [1:0] ST_REFUSED  = 2'd2;

endpackage

// ----- hw/rtl/rsrf_ram.sv -----
module rsrf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/replacement_selection_run_former.sv -----
// replacement-selection run former for external sorting, min-heap in one ram
// input channel (in_valid/in_ready): action and value. a load item inserts
// value into the active heap (ignored when the store is full). a record item
// pops the heap minimum as the next run key; the record re-enters the heap
// if it is not below that minimum, otherwise it is frozen for the next run.
// a next-run item moves the frozen keys to the front and heapifies them.
// output channel (out_valid/out_ready): one item per record, none otherwise.
// in_ready is high only while the sequencer is idle; one item at a time.
// per item: a load or record sifts its key through L heap levels, L being at
// most log2 of the heap size. a load with frozen keys present first moves one
// frozen key to the end of the frozen region; a deferred record also reads the
// last heap key and writes itself past the heap. a next run copies the frozen
// keys, then sifts down from each interior node. one ram write port and
// registered reads set the pace: each heap level costs a read and a compare
// with write-back. a result waits in the output register while the receiver
// stalls; the block still takes the next item and only holds when a second
// result is ready. reset clears counters and control; the ram needs no
// clearing, as no entry's value is used before it is written.
module replacement_selection_run_former #(
    parameter int unsigned STORE_DEPTH = rsrf_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        action,
    input  logic signed [rsrf_pkg::KEY_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rsrf_pkg::KEY_W-1:0] run_key,
    output logic [1:0]                        status,
    output logic                              run_ended
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned KW = rsrf_pkg::KEY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LMOVE,
        S_UP_RD,
        S_UP_CMP,
        S_R_MIN,
        S_R_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_PUT,
        S_EMIT,
        S_C_WR,
        S_H_INIT,
        S_H_LD
    } state_t;

    typedef enum logic [1:0] {
        M_DONE,
        M_PUT,
        M_HEAP
    } mode_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [CW-1:0]     hc_reg, hc_next;
    logic [CW-1:0]     dc_reg, dc_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic signed [KW-1:0] key_reg, key_next;
    logic signed [KW-1:0] mov_reg, mov_next;
    logic signed [KW-1:0] min_reg, min_next;
    logic [1:0]        st_reg, st_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [KW-1:0] run_key_reg, run_key_next;
    logic [1:0]        status_reg, status_next;
    logic              run_ended_reg, run_ended_next;

    // ram port signals
    logic          we;
    logic [AW-1:0] waddr;
    logic [KW-1:0] wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [KW-1:0] rdata_a;
    logic [KW-1:0] rdata_b;

    // derived addresses and limits
    logic [CW:0]     fill;
    logic            full;
    logic [AW+1:0]   l_ext;
    logic [AW+1:0]   r_ext;
    logic [AW+1:0]   lim_ext;
    logic            l_ok;
    logic            r_ok;
    logic [AW-1:0]   parent;
    logic [CW-1:0]   idx_inc;
    logic [CW:0]     copy_src;
    logic [CW-1:0]   hc_dec;
    logic signed [KW-1:0] lkey;
    logic signed [KW-1:0] rkey;
    logic signed [KW-1:0] ckey;
    logic [AW-1:0]   caddr;
    logic            sift_end;

    rsrf_ram #(
        .WIDTH (KW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // occupancy and heap index arithmetic
    assign fill     = {1'b0, hc_reg} + {1'b0, dc_reg};
    assign full     = fill >= (CW+1)'(STORE_DEPTH);
    assign l_ext    = {1'b0, pos_reg, 1'b1};
    assign r_ext    = l_ext + 1'b1;
    assign lim_ext  = (AW+2)'(lim_reg);
    assign l_ok     = l_ext < lim_ext;
    assign r_ok     = r_ext < lim_ext;
    assign parent   = (pos_reg - 1'b1) >> 1;
    assign idx_inc  = CW'(idx_reg) + 1'b1;
    assign copy_src = {1'b0, hc_reg} + {1'b0, idx_inc};
    assign hc_dec   = hc_reg - 1'b1;

    // smaller child, left wins a tie
    assign lkey  = $signed(rdata_a);
    assign rkey  = $signed(rdata_b);
    assign ckey  = (r_ok && (rkey < lkey)) ? rkey : lkey;
    assign caddr = (r_ok && (rkey < lkey)) ? r_ext[AW-1:0] : l_ext[AW-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign run_key   = run_key_reg;
    assign status    = status_reg;
    assign run_ended = run_ended_reg;

    // sequencer next state and ram control
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        hc_next        = hc_reg;
        dc_next        = dc_reg;
        lim_next       = lim_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        mov_next       = mov_reg;
        min_next       = min_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        run_key_next   = run_key_reg;
        status_next    = status_reg;
        run_ended_next = run_ended_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = mov_reg;
        raddr_a        = '0;
        raddr_b        = '0;
        sift_end       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = value;
                    mov_next = value;
                    unique case (action)
                        rsrf_pkg::ACT_LOAD:
                        begin
                            if (!full)
                            begin
                                if (dc_reg != '0)
                                begin
                                    raddr_a    = hc_reg[AW-1:0];
                                    state_next = S_LMOVE;
                                end
                                else
                                begin
                                    pos_next   = hc_reg[AW-1:0];
                                    hc_next    = hc_reg + 1'b1;
                                    state_next = S_UP_RD;
                                end
                            end
                        end
                        rsrf_pkg::ACT_RECORD:
                        begin
                            if (hc_reg == '0)
                            begin
                                min_next   = '0;
                                st_next    = rsrf_pkg::ST_REFUSED;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                raddr_a    = '0;
                                state_next = S_R_MIN;
                            end
                        end
                        rsrf_pkg::ACT_NEXT:
                        begin
                            if ((dc_reg != '0) && (hc_reg != '0))
                            begin
                                idx_next   = '0;
                                raddr_a    = hc_reg[AW-1:0];
                                state_next = S_C_WR;
                            end
                            else
                            begin
                                state_next = S_H_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // move the first frozen key to the end of the frozen region
            S_LMOVE:
            begin
                we         = 1'b1;
                waddr      = fill[AW-1:0];
                wdata      = rdata_a;
                pos_next   = hc_reg[AW-1:0];
                hc_next    = hc_reg + 1'b1;
                state_next = S_UP_RD;
            end

            // sift-up: fetch parent of the hole
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr_a    = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                we = 1'b1;
                if (mov_reg < lkey)
                begin
                    wdata      = rdata_a;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // record: minimum known, decide enter or defer
            S_R_MIN:
            begin
                min_next = lkey;
                if (key_reg >= lkey)
                begin
                    mov_next   = key_reg;
                    pos_next   = '0;
                    lim_next   = hc_reg;
                    st_next    = rsrf_pkg::ST_ENTERED;
                    mode_next  = M_DONE;
                    state_next = S_DN_RD;
                end
                else
                begin
                    hc_next    = hc_dec;
                    raddr_a    = hc_dec[AW-1:0];
                    st_next    = rsrf_pkg::ST_DEFERRED;
                    state_next = S_R_LAST;
                end
            end

            S_R_LAST:
            begin
                mov_next   = lkey;
                pos_next   = '0;
                lim_next   = hc_reg;
                mode_next  = M_PUT;
                state_next = S_DN_RD;
            end

            // sift-down: fetch both children of the hole
            S_DN_RD:
            begin
                if (l_ok)
                begin
                    raddr_a    = l_ext[AW-1:0];
                    raddr_b    = r_ext[AW-1:0];
                    state_next = S_DN_CMP;
                end
                else
                begin
                    we       = 1'b1;
                    sift_end = 1'b1;
                end
            end

            S_DN_CMP:
            begin
                we = 1'b1;
                if (ckey < mov_reg)
                begin
                    wdata      = ckey;
                    pos_next   = caddr;
                    state_next = S_DN_RD;
                end
                else
                begin
                    sift_end = 1'b1;
                end
            end

            // frozen record goes just past the shrunken heap
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = hc_reg[AW-1:0];
                wdata      = key_reg;
                dc_next    = dc_reg + 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    run_key_next   = min_reg;
                    status_next    = st_reg;
                    run_ended_next = (hc_reg == '0);
                    state_next     = S_IDLE;
                end
            end

            // copy frozen keys to the front, one per cycle
            S_C_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rdata_a;
                if (idx_inc == dc_reg)
                begin
                    state_next = S_H_INIT;
                end
                else
                begin
                    idx_next = idx_inc[AW-1:0];
                    raddr_a  = copy_src[AW-1:0];
                end
            end

            S_H_INIT:
            begin
                hc_next  = dc_reg;
                dc_next  = '0;
                idx_next = AW'(dc_reg >> 1);
                if (dc_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr_a    = AW'(dc_reg >> 1);
                    state_next = S_H_LD;
                end
            end

            S_H_LD:
            begin
                mov_next   = lkey;
                pos_next   = idx_reg;
                lim_next   = hc_reg;
                mode_next  = M_HEAP;
                state_next = S_DN_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // continuation after a sift-down
        if (sift_end)
        begin
            case (mode_reg)
                M_DONE:
                begin
                    state_next = S_EMIT;
                end
                M_PUT:
                begin
                    state_next = S_PUT;
                end
                default:
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        raddr_a    = idx_reg - 1'b1;
                        state_next = S_H_LD;
                    end
                end
            endcase
        end
    end

    // state, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_DONE;
            hc_reg        <= '0;
            dc_reg        <= '0;
            lim_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            key_reg       <= '0;
            mov_reg       <= '0;
            min_reg       <= '0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
            run_key_reg   <= '0;
            status_reg    <= '0;
            run_ended_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            hc_reg        <= hc_next;
            dc_reg        <= dc_next;
            lim_reg       <= lim_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            key_reg       <= key_next;
            mov_reg       <= mov_next;
            min_reg       <= min_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            run_key_reg   <= run_key_next;
            status_reg    <= status_next;
            run_ended_reg <= run_ended_next;
        end
    end

    // store never overfills
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= (CW+1)'(STORE_DEPTH))
        else $error("heap plus frozen keys exceed the store");

    // frozen count only grows when a deferred record is written
    a_defer_source: assert property (@(posedge clk) disable iff (!rst_n)
        (dc_reg > $past(dc_reg)) |-> ($past(state_reg) == S_PUT))
        else $error("frozen count grew outside the put step");

    // a hole being compared always lies inside the heap
    a_hole_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_CMP) |-> ((AW+2)'(pos_reg) < lim_ext))
        else $error("sift-down hole outside the heap");

    // a refused record carries a zero key and marks the run ended
    a_refused_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == rsrf_pkg::ST_REFUSED))
            |-> ((run_key_reg == '0) && run_ended_reg))
        else $error("refused item with key or open run");

endmodule
